### rtl/core/fnbc_pkg.sv
package fnbc_pkg;

   localparam int CoordW  = 32;
   localparam int EdgeW   = 33;   // coordinate difference
   localparam int ProdW   = 66;   // edge by edge product
   localparam int CrossW  = 67;   // cross product component
   localparam int MagW    = 65;   // magnitude of a cross component
   localparam int LoW     = 33;   // low part of a magnitude for the split square
   localparam int HiW     = MagW - LoW;
   localparam int SqW     = 130;  // square of a magnitude
   localparam int SumW    = 132;  // squared length
   localparam int ResW    = 168;  // root step remainder and partial product
   localparam int QW      = 15;   // scaled magnitude, 0 .. 16384
   localparam int NumBits = QW;
   localparam int UnitW   = 16;
   localparam int CodeW   = 8;
   localparam int CsrIdxW = 3;
   localparam int NumCodes = 6;
   localparam int FracSh  = 30;   // 2^30 = (2 * 16384)^2
   localparam logic [QW-1:0] Thresh = QW'(9830);
   localparam int Latency = 24;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_NEG_X = 3'd0,
      CSR_POS_X = 3'd1,
      CSR_NEG_Y = 3'd2,
      CSR_POS_Y = 3'd3,
      CSR_NEG_Z = 3'd4,
      CSR_POS_Z = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic             valid;
      logic [CodeW-1:0] code;
      logic [2:0]       neg;
      logic             degen;
   } side_type;

endpackage

### rtl/core/fnbc_cross.sv
module fnbc_cross (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic signed [fnbc_pkg::CoordW-1:0]    a_x,
   input  logic signed [fnbc_pkg::CoordW-1:0]    a_y,
   input  logic signed [fnbc_pkg::CoordW-1:0]    a_z,
   input  logic signed [fnbc_pkg::CoordW-1:0]    b_x,
   input  logic signed [fnbc_pkg::CoordW-1:0]    b_y,
   input  logic signed [fnbc_pkg::CoordW-1:0]    b_z,
   input  logic signed [fnbc_pkg::CoordW-1:0]    c_x,
   input  logic signed [fnbc_pkg::CoordW-1:0]    c_y,
   input  logic signed [fnbc_pkg::CoordW-1:0]    c_z,
   input  logic [fnbc_pkg::CodeW-1:0]            code_in,
   output fnbc_pkg::side_type                    side_out,
   output logic [2:0][fnbc_pkg::MagW-1:0]        mag_out
);

   fnbc_pkg::side_type side_ff [4];

   logic signed [fnbc_pkg::EdgeW-1:0]  e1x_ff, e1y_ff, e1z_ff, e2x_ff, e2y_ff, e2z_ff;
   logic signed [fnbc_pkg::ProdW-1:0]  prod_ff [6];
   logic signed [fnbc_pkg::CrossW-1:0] cr_ff [3];
   logic [2:0][fnbc_pkg::MagW-1:0]     mag_ff;
   logic signed [fnbc_pkg::CrossW-1:0] abs_in [3];
   logic [2:0]                         neg_in;
   fnbc_pkg::side_type                 side_in;

   always_comb begin
      side_in       = '0;
      side_in.valid = in_valid;
      side_in.code  = code_in;
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = cr_ff[i][fnbc_pkg::CrossW-1];
         abs_in[i] = neg_in[i] ? -cr_ff[i] : cr_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) side_ff[i] <= '0;
      end else begin
         side_ff[0] <= side_in;
         side_ff[1] <= side_ff[0];
         side_ff[2] <= side_ff[1];
         side_ff[3].valid <= side_ff[2].valid;
         side_ff[3].code  <= side_ff[2].code;
         side_ff[3].neg   <= neg_in;
         side_ff[3].degen <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      e1x_ff <= {b_x[fnbc_pkg::CoordW-1], b_x} - {a_x[fnbc_pkg::CoordW-1], a_x};
      e1y_ff <= {b_y[fnbc_pkg::CoordW-1], b_y} - {a_y[fnbc_pkg::CoordW-1], a_y};
      e1z_ff <= {b_z[fnbc_pkg::CoordW-1], b_z} - {a_z[fnbc_pkg::CoordW-1], a_z};
      e2x_ff <= {c_x[fnbc_pkg::CoordW-1], c_x} - {a_x[fnbc_pkg::CoordW-1], a_x};
      e2y_ff <= {c_y[fnbc_pkg::CoordW-1], c_y} - {a_y[fnbc_pkg::CoordW-1], a_y};
      e2z_ff <= {c_z[fnbc_pkg::CoordW-1], c_z} - {a_z[fnbc_pkg::CoordW-1], a_z};
      prod_ff[0] <= fnbc_pkg::ProdW'(e1y_ff * e2z_ff);
      prod_ff[1] <= fnbc_pkg::ProdW'(e2y_ff * e1z_ff);
      prod_ff[2] <= fnbc_pkg::ProdW'(e1z_ff * e2x_ff);
      prod_ff[3] <= fnbc_pkg::ProdW'(e1x_ff * e2z_ff);
      prod_ff[4] <= fnbc_pkg::ProdW'(e1x_ff * e2y_ff);
      prod_ff[5] <= fnbc_pkg::ProdW'(e2x_ff * e1y_ff);
      for (int i = 0; i < 3; i++) begin
         cr_ff[i] <= fnbc_pkg::CrossW'(prod_ff[2*i]) - fnbc_pkg::CrossW'(prod_ff[2*i+1]);
      end
      for (int i = 0; i < 3; i++) begin
         mag_ff[i] <= abs_in[i][fnbc_pkg::MagW-1:0];
      end
   end

   assign side_out = side_ff[3];
   assign mag_out  = mag_ff;

endmodule

### rtl/core/fnbc_square.sv
module fnbc_square (
   input  logic                               clock,
   input  logic                               reset,
   input  fnbc_pkg::side_type                 side_in,
   input  logic [2:0][fnbc_pkg::MagW-1:0]     mag_in,
   output fnbc_pkg::side_type                 side_out,
   output logic [2:0][fnbc_pkg::SqW-1:0]      sq_out,
   output logic [fnbc_pkg::SumW-1:0]          sum_out
);

   localparam int HhW = 2 * fnbc_pkg::HiW;
   localparam int HlW = fnbc_pkg::HiW + fnbc_pkg::LoW;
   localparam int LlW = 2 * fnbc_pkg::LoW;

   fnbc_pkg::side_type side_ff [3];

   logic [HhW-1:0]                    hh_ff [3];
   logic [HlW-1:0]                    hl_ff [3];
   logic [LlW-1:0]                    ll_ff [3];
   logic [2:0][fnbc_pkg::SqW-1:0]     sq_ff, sq2_ff;
   logic [fnbc_pkg::SumW-1:0]         sum_ff;
   logic                              zero_in;
   fnbc_pkg::side_type                side_last_in;

   assign zero_in = (sq_ff[0] == '0) && (sq_ff[1] == '0) && (sq_ff[2] == '0);

   always_comb begin
      side_last_in       = side_ff[1];
      side_last_in.degen = zero_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) side_ff[i] <= '0;
      end else begin
         side_ff[0] <= side_in;
         side_ff[1] <= side_ff[0];
         side_ff[2] <= side_last_in;
      end
   end

   // split square: m = hi * 2^LoW + lo
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         hh_ff[i] <= mag_in[i][fnbc_pkg::MagW-1:fnbc_pkg::LoW]
                   * mag_in[i][fnbc_pkg::MagW-1:fnbc_pkg::LoW];
         hl_ff[i] <= HlW'(mag_in[i][fnbc_pkg::MagW-1:fnbc_pkg::LoW])
                   * HlW'(mag_in[i][fnbc_pkg::LoW-1:0]);
         ll_ff[i] <= LlW'(mag_in[i][fnbc_pkg::LoW-1:0]) * LlW'(mag_in[i][fnbc_pkg::LoW-1:0]);
         sq_ff[i] <= (fnbc_pkg::SqW'(hh_ff[i]) << (2 * fnbc_pkg::LoW))
                   + (fnbc_pkg::SqW'(hl_ff[i]) << (fnbc_pkg::LoW + 1))
                   + fnbc_pkg::SqW'(ll_ff[i]);
      end
      sq2_ff <= sq_ff;
      sum_ff <= fnbc_pkg::SumW'(sq_ff[0]) + fnbc_pkg::SumW'(sq_ff[1])
              + fnbc_pkg::SumW'(sq_ff[2]);
   end

   assign side_out = side_ff[2];
   assign sq_out   = sq2_ff;
   assign sum_out  = sum_ff;

endmodule

### rtl/core/fnbc_root.sv
// Greedy bit search for the largest q with 2^30*m^2 >= (2q-1)^2 * s.
// Keeps r = 2^30*m^2 - x^2*s and p = x*s for x = 2q-1, so each step is
// shifts and one three-input add.
module fnbc_root (
   input  logic                               clock,
   input  logic                               reset,
   input  fnbc_pkg::side_type                 side_in,
   input  logic [2:0][fnbc_pkg::SqW-1:0]      sq_in,
   input  logic [fnbc_pkg::SumW-1:0]          sum_in,
   output fnbc_pkg::side_type                 side_out,
   output logic [2:0][fnbc_pkg::QW-1:0]       q_out
);

   localparam int N = fnbc_pkg::NumBits;

   fnbc_pkg::side_type                side_ff [N+1];
   logic [fnbc_pkg::SumW-1:0]         s_ff    [N+1];
   logic signed [fnbc_pkg::ResW-1:0]  r_ff    [N+1][3];
   logic signed [fnbc_pkg::ResW-1:0]  p_ff    [N+1][3];
   logic [fnbc_pkg::QW-1:0]           q_ff    [N+1][3];

   logic signed [fnbc_pkg::ResW-1:0]  s_in_w;
   logic signed [fnbc_pkg::ResW-1:0]  t_in [3];

   always_comb begin
      s_in_w = $signed({{(fnbc_pkg::ResW - fnbc_pkg::SumW){1'b0}}, sum_in});
      for (int i = 0; i < 3; i++) begin
         t_in[i] = $signed({{(fnbc_pkg::ResW - fnbc_pkg::SqW){1'b0}}, sq_in[i]})
                   <<< fnbc_pkg::FracSh;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) side_ff[0] <= '0;
      else       side_ff[0] <= side_in;
   end

   // start from q = 0, x = -1
   always_ff @(posedge clock) begin
      s_ff[0] <= sum_in;
      for (int i = 0; i < 3; i++) begin
         r_ff[0][i] <= t_in[i] - s_in_w;
         p_ff[0][i] <= -s_in_w;
         q_ff[0][i] <= '0;
      end
   end

   for (genvar j = 0; j < N; j++) begin : g_step
      localparam int K = N - 1 - j;

      logic signed [fnbc_pkg::ResW-1:0] s_w;
      logic signed [fnbc_pkg::ResW-1:0] d_in [3];

      always_comb begin
         s_w = $signed({{(fnbc_pkg::ResW - fnbc_pkg::SumW){1'b0}}, s_ff[j]});
         for (int i = 0; i < 3; i++) begin
            d_in[i] = r_ff[j][i] - (p_ff[j][i] <<< (K + 2)) - (s_w <<< (2 * K + 2));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) side_ff[j+1] <= '0;
         else       side_ff[j+1] <= side_ff[j];
      end

      always_ff @(posedge clock) begin
         s_ff[j+1] <= s_ff[j];
         for (int i = 0; i < 3; i++) begin
            if (!d_in[i][fnbc_pkg::ResW-1]) begin
               r_ff[j+1][i] <= d_in[i];
               p_ff[j+1][i] <= p_ff[j][i] + (s_w <<< (K + 1));
               q_ff[j+1][i] <= q_ff[j][i] | (fnbc_pkg::QW'(1) << K);
            end else begin
               r_ff[j+1][i] <= r_ff[j][i];
               p_ff[j+1][i] <= p_ff[j][i];
               q_ff[j+1][i] <= q_ff[j][i];
            end
         end
      end
   end

   assign side_out = side_ff[N];
   always_comb begin
      for (int i = 0; i < 3; i++) q_out[i] = q_ff[N][i];
   end

endmodule

### rtl/core/fnbc_classify.sv
module fnbc_classify (
   input  logic                                     clock,
   input  logic                                     reset,
   input  fnbc_pkg::side_type                       side_in,
   input  logic [2:0][fnbc_pkg::QW-1:0]             q_in,
   input  logic [fnbc_pkg::NumCodes-1:0][fnbc_pkg::CodeW-1:0] codes,
   output logic                                     strobe,
   output logic signed [fnbc_pkg::UnitW-1:0]        unit_x,
   output logic signed [fnbc_pkg::UnitW-1:0]        unit_y,
   output logic signed [fnbc_pkg::UnitW-1:0]        unit_z,
   output logic [fnbc_pkg::CodeW-1:0]               code_out,
   output logic                                     degenerate
);

   logic                               strobe_ff;
   logic signed [fnbc_pkg::UnitW-1:0]  unit_ff [3];
   logic [fnbc_pkg::CodeW-1:0]         code_ff;
   logic                               degen_ff;

   logic signed [fnbc_pkg::UnitW-1:0]  unit_in [3];
   logic [fnbc_pkg::CodeW-1:0]         code_in;
   logic [fnbc_pkg::NumCodes-1:0]      hit;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (side_in.degen) begin
            unit_in[i] = '0;
         end else if (side_in.neg[i]) begin
            unit_in[i] = -$signed({1'b0, q_in[i]});
         end else begin
            unit_in[i] = $signed({1'b0, q_in[i]});
         end
         hit[2*i]   = side_in.neg[i]  && (q_in[i] > fnbc_pkg::Thresh)
                      && (codes[2*i] != '0);
         hit[2*i+1] = !side_in.neg[i] && (q_in[i] > fnbc_pkg::Thresh)
                      && (codes[2*i+1] != '0);
      end
      code_in = side_in.code;
      // later direction wins
      if (!side_in.degen && side_in.code != '0) begin
         for (int c = 0; c < fnbc_pkg::NumCodes; c++) begin
            if (hit[c]) code_in = codes[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) strobe_ff <= 1'b0;
      else       strobe_ff <= side_in.valid;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) unit_ff[i] <= unit_in[i];
      code_ff  <= code_in;
      degen_ff <= side_in.degen;
   end

   assign strobe     = strobe_ff;
   assign unit_x     = unit_ff[0];
   assign unit_y     = unit_ff[1];
   assign unit_z     = unit_ff[2];
   assign code_out   = code_ff;
   assign degenerate = degen_ff;

endmodule

### rtl/core/face_normal_bc_classifier_top.sv
// Channel   Handshake           Payload
// request   start / busy        req_a_* req_b_* req_c_* req_code_in
// response  rsp_strobe          rsp_unit_x/y/z rsp_code_out rsp_degenerate
// config    csr_we              csr_index csr_wdata
//
// One transaction enters every cycle; busy stays low.
// Each result passes the cross product and square stages, then the 15-step
// greedy square-root/divide search, and then the classify register.
// Synchronous active-high reset clears valid bits and the code registers.
// The receiver cannot stall, so the pipeline always advances.
module face_normal_bc_classifier_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [fnbc_pkg::CoordW-1:0]    req_a_x,
   input  logic signed [fnbc_pkg::CoordW-1:0]    req_a_y,
   input  logic signed [fnbc_pkg::CoordW-1:0]    req_a_z,
   input  logic signed [fnbc_pkg::CoordW-1:0]    req_b_x,
   input  logic signed [fnbc_pkg::CoordW-1:0]    req_b_y,
   input  logic signed [fnbc_pkg::CoordW-1:0]    req_b_z,
   input  logic signed [fnbc_pkg::CoordW-1:0]    req_c_x,
   input  logic signed [fnbc_pkg::CoordW-1:0]    req_c_y,
   input  logic signed [fnbc_pkg::CoordW-1:0]    req_c_z,
   input  logic [fnbc_pkg::CodeW-1:0]            req_code_in,
   output logic                                  rsp_strobe,
   output logic signed [fnbc_pkg::UnitW-1:0]     rsp_unit_x,
   output logic signed [fnbc_pkg::UnitW-1:0]     rsp_unit_y,
   output logic signed [fnbc_pkg::UnitW-1:0]     rsp_unit_z,
   output logic [fnbc_pkg::CodeW-1:0]            rsp_code_out,
   output logic                                  rsp_degenerate,
   input  logic                                  csr_we,
   input  logic [fnbc_pkg::CsrIdxW-1:0]          csr_index,
   input  logic [fnbc_pkg::CodeW-1:0]            csr_wdata
);

   logic [fnbc_pkg::NumCodes-1:0][fnbc_pkg::CodeW-1:0] codes_ff;

   fnbc_pkg::side_type                  cross_side, sq_side, root_side;
   logic [2:0][fnbc_pkg::MagW-1:0]      mag;
   logic [2:0][fnbc_pkg::SqW-1:0]       sq;
   logic [fnbc_pkg::SumW-1:0]           sum;
   logic [2:0][fnbc_pkg::QW-1:0]        q;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff <= '0;
      end else if (csr_we) begin
         unique case (fnbc_pkg::csr_index_type'(csr_index))
            fnbc_pkg::CSR_NEG_X: codes_ff[0] <= csr_wdata;
            fnbc_pkg::CSR_POS_X: codes_ff[1] <= csr_wdata;
            fnbc_pkg::CSR_NEG_Y: codes_ff[2] <= csr_wdata;
            fnbc_pkg::CSR_POS_Y: codes_ff[3] <= csr_wdata;
            fnbc_pkg::CSR_NEG_Z: codes_ff[4] <= csr_wdata;
            fnbc_pkg::CSR_POS_Z: codes_ff[5] <= csr_wdata;
            default: ;
         endcase
      end
   end

   fnbc_cross u_cross (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .a_x      (req_a_x),
      .a_y      (req_a_y),
      .a_z      (req_a_z),
      .b_x      (req_b_x),
      .b_y      (req_b_y),
      .b_z      (req_b_z),
      .c_x      (req_c_x),
      .c_y      (req_c_y),
      .c_z      (req_c_z),
      .code_in  (req_code_in),
      .side_out (cross_side),
      .mag_out  (mag)
   );

   fnbc_square u_square (
      .clock    (clock),
      .reset    (reset),
      .side_in  (cross_side),
      .mag_in   (mag),
      .side_out (sq_side),
      .sq_out   (sq),
      .sum_out  (sum)
   );

   fnbc_root u_root (
      .clock    (clock),
      .reset    (reset),
      .side_in  (sq_side),
      .sq_in    (sq),
      .sum_in   (sum),
      .side_out (root_side),
      .q_out    (q)
   );

   fnbc_classify u_classify (
      .clock      (clock),
      .reset      (reset),
      .side_in    (root_side),
      .q_in       (q),
      .codes      (codes_ff),
      .strobe     (rsp_strobe),
      .unit_x     (rsp_unit_x),
      .unit_y     (rsp_unit_y),
      .unit_z     (rsp_unit_z),
      .code_out   (rsp_code_out),
      .degenerate (rsp_degenerate)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##24 rsp_strobe)
      else $error("transaction did not complete on schedule");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_degenerate) |->
         (rsp_unit_x == '0 && rsp_unit_y == '0 && rsp_unit_z == '0))
      else $error("degenerate face with nonzero normal");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_unit_x <= 16'sd16384 && rsp_unit_x >= -16'sd16384 &&
                      rsp_unit_y <= 16'sd16384 && rsp_unit_y >= -16'sd16384 &&
                      rsp_unit_z <= 16'sd16384 && rsp_unit_z >= -16'sd16384))
      else $error("unit normal component out of range");

   a_no_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      (!$past(start, 24)) |-> !rsp_strobe)
      else $error("result without transaction");

endmodule

### tb/sv/testbench.sv
module testbench;

   typedef logic signed [fnbc_pkg::CoordW-1:0] coord_type;

   typedef struct {
      coord_type                  pt[9];
      logic [fnbc_pkg::CodeW-1:0] code;
   } face_type;

   typedef struct {
      logic signed [fnbc_pkg::UnitW-1:0] unit[3];
      logic [fnbc_pkg::CodeW-1:0]        code;
      logic                              degen;
   } normal_type;

   class normal_scoreboard;
      logic [fnbc_pkg::CodeW-1:0] dir_code[fnbc_pkg::NumCodes];
      normal_type                 pending[$];
      int                         mismatches;

      function new();
         foreach (dir_code[i]) dir_code[i] = '0;
         mismatches = 0;
      endfunction

      // Round 16384 * m / sqrt(s) to nearest: largest q with 2^30 m^2 >= (2q-1)^2 s.
      function int scaled_mag(logic [199:0] m, logic [199:0] s);
         logic [199:0] lhs;
         logic [199:0] rhs;
         int lo;
         int hi;
         int mid;
         lhs = (m * m) << fnbc_pkg::FracSh;
         lo = 0;
         hi = 16384;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            rhs = s * 200'((2 * mid - 1) * (2 * mid - 1));
            if (lhs >= rhs) lo = mid;
            else hi = mid - 1;
         end
         return lo;
      endfunction

      function normal_type face_normal(face_type f);
         normal_type         r;
         logic signed [66:0] e1[3];
         logic signed [66:0] e2[3];
         logic signed [66:0] cr[3];
         logic [199:0]       mag[3];
         logic [199:0]       len2;
         int                 u[3];
         int                 th;
         for (int i = 0; i < 3; i++) begin
            e1[i] = 67'(f.pt[3+i]) - 67'(f.pt[i]);
            e2[i] = 67'(f.pt[6+i]) - 67'(f.pt[i]);
         end
         cr[0] = e1[1] * e2[2] - e2[1] * e1[2];
         cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
         cr[2] = e1[0] * e2[1] - e2[0] * e1[1];
         len2 = '0;
         for (int i = 0; i < 3; i++) begin
            mag[i] = cr[i][66] ? 200'(-cr[i]) : 200'(cr[i]);
            len2 = len2 + mag[i] * mag[i];
         end
         r.code = f.code;
         r.degen = (len2 == 0);
         for (int i = 0; i < 3; i++) u[i] = 0;
         if (!r.degen) begin
            for (int i = 0; i < 3; i++) begin
               u[i] = scaled_mag(mag[i], len2);
               if (cr[i][66]) u[i] = -u[i];
            end
            th = int'(fnbc_pkg::Thresh);
            // later directions override earlier ones
            if (r.code != 0) begin
               if (dir_code[fnbc_pkg::CSR_NEG_X] != 0 && u[0] < -th)
                  r.code = dir_code[fnbc_pkg::CSR_NEG_X];
               if (dir_code[fnbc_pkg::CSR_POS_X] != 0 && u[0] > th)
                  r.code = dir_code[fnbc_pkg::CSR_POS_X];
               if (dir_code[fnbc_pkg::CSR_NEG_Y] != 0 && u[1] < -th)
                  r.code = dir_code[fnbc_pkg::CSR_NEG_Y];
               if (dir_code[fnbc_pkg::CSR_POS_Y] != 0 && u[1] > th)
                  r.code = dir_code[fnbc_pkg::CSR_POS_Y];
               if (dir_code[fnbc_pkg::CSR_NEG_Z] != 0 && u[2] < -th)
                  r.code = dir_code[fnbc_pkg::CSR_NEG_Z];
               if (dir_code[fnbc_pkg::CSR_POS_Z] != 0 && u[2] > th)
                  r.code = dir_code[fnbc_pkg::CSR_POS_Z];
            end
         end
         for (int i = 0; i < 3; i++) r.unit[i] = fnbc_pkg::UnitW'(u[i]);
         return r;
      endfunction

      function void note_face(face_type f);
         pending.push_back(face_normal(f));
      endfunction

      function void check_normal(normal_type got);
         normal_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transaction");
            return;
         end
         want = pending.pop_front();
         if (got.unit[0] !== want.unit[0] || got.unit[1] !== want.unit[1] ||
             got.unit[2] !== want.unit[2] || got.code !== want.code ||
             got.degen !== want.degen) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: exp %0d %0d %0d code %0d deg %0d, ",
                         "got %0d %0d %0d code %0d deg %0d"},
                        want.unit[0], want.unit[1], want.unit[2], want.code, want.degen,
                        got.unit[0], got.unit[1], got.unit[2], got.code, got.degen);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   coord_type req_a_x = '0, req_a_y = '0, req_a_z = '0;
   coord_type req_b_x = '0, req_b_y = '0, req_b_z = '0;
   coord_type req_c_x = '0, req_c_y = '0, req_c_z = '0;
   logic [fnbc_pkg::CodeW-1:0] req_code_in = '0;
   logic rsp_strobe;
   logic signed [fnbc_pkg::UnitW-1:0] rsp_unit_x, rsp_unit_y, rsp_unit_z;
   logic [fnbc_pkg::CodeW-1:0] rsp_code_out;
   logic rsp_degenerate;
   logic csr_we = 1'b0;
   logic [fnbc_pkg::CsrIdxW-1:0] csr_index = '0;
   logic [fnbc_pkg::CodeW-1:0] csr_wdata = '0;

   normal_scoreboard sb = new();
   int cycles = 0;
   bit quiet = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   face_normal_bc_classifier_top u_top (.*);

   always @(posedge clock) begin
      face_type   f;
      normal_type n;
      cycles <= cycles + 1;
      if (cycles > 200000) begin
         $display("[face_normal_bc_classifier_top] ERROR");
         $finish;
      end
      if (!reset && start && !busy) begin
         f.pt = '{req_a_x, req_a_y, req_a_z, req_b_x, req_b_y, req_b_z,
                  req_c_x, req_c_y, req_c_z};
         f.code = req_code_in;
         sb.note_face(f);
      end
      if (!reset && rsp_strobe) begin
         n.unit = '{rsp_unit_x, rsp_unit_y, rsp_unit_z};
         n.code = rsp_code_out;
         n.degen = rsp_degenerate;
         sb.check_normal(n);
      end
   end

   task automatic send_face(face_type f);
      if (!quiet && $urandom_range(99) < 31) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      {req_a_x, req_a_y, req_a_z} <= {f.pt[0], f.pt[1], f.pt[2]};
      {req_b_x, req_b_y, req_b_z} <= {f.pt[3], f.pt[4], f.pt[5]};
      {req_c_x, req_c_y, req_c_z} <= {f.pt[6], f.pt[7], f.pt[8]};
      req_code_in <= f.code;
      do @(posedge clock); while (busy);
   endtask

   // Drain, then let in-flight work retire before touching the code table.
   task automatic write_codes(logic [fnbc_pkg::CodeW-1:0] v[fnbc_pkg::NumCodes]);
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (fnbc_pkg::Latency + 4) @(posedge clock);
      for (int i = 0; i < fnbc_pkg::NumCodes; i++) begin
         csr_we <= 1'b1;
         csr_index <= fnbc_pkg::csr_index_type'(i);
         csr_wdata <= v[i];
         sb.dir_code[i] = v[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function automatic face_type axis_face(int axis, bit flip, int span);
      face_type f;
      int       u1, u2;
      u1 = (axis + 1) % 3;
      u2 = (axis + 2) % 3;
      for (int i = 0; i < 3; i++) f.pt[i] = coord_type'($urandom);
      for (int i = 0; i < 3; i++) begin
         f.pt[3+i] = f.pt[i] + coord_type'($urandom_range(span) - span / 2) / 8;
         f.pt[6+i] = f.pt[i] + coord_type'($urandom_range(span) - span / 2) / 8;
      end
      f.pt[3+u1] = f.pt[u1] + coord_type'($urandom_range(span, 1));
      f.pt[6+u2] = f.pt[u2] + coord_type'(flip ? -$urandom_range(span, 1)
                                               : $urandom_range(span, 1));
      f.code = 8'($urandom_range(255, 1));
      return f;
   endfunction

   function automatic face_type random_face();
      face_type f;
      int       kind;
      kind = $urandom_range(99);
      if (kind < 40)
         return axis_face($urandom_range(2), 1'($urandom_range(1)), 1 << 20);
      for (int i = 0; i < 9; i++) begin
         if (kind < 70) f.pt[i] = coord_type'($urandom_range(8191)) - 4096;
         else f.pt[i] = coord_type'($urandom);
      end
      if (kind >= 90) begin
         // collinear or repeated points
         for (int i = 0; i < 3; i++) f.pt[6+i] = f.pt[i] + 2 * (f.pt[3+i] - f.pt[i]);
         if (kind >= 95) for (int i = 0; i < 3; i++) f.pt[3+i] = f.pt[i];
      end
      f.code = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom);
      return f;
   endfunction

   initial begin
      face_type f;
      logic [fnbc_pkg::CodeW-1:0] tbl[fnbc_pkg::NumCodes];
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset table, then full table
      for (int ph = 0; ph < 2; ph++) begin
         if (ph == 1) begin
            tbl = '{8'd11, 8'd22, 8'd33, 8'd44, 8'd55, 8'd66};
            write_codes(tbl);
         end
         for (int a = 0; a < 3; a++)
            for (int s = 0; s < 2; s++) send_face(axis_face(a, 1'(s), 1 << 16));
         f.pt = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff};
         f.code = 8'hff;
         send_face(f);
         f.pt = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
         send_face(f);
         f.pt = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
         f.code = 8'd0;
         send_face(f);
         f.pt = '{5, 5, 5, 5, 5, 5, 5, 5, 5};
         f.code = 8'd7;
         send_face(f);
         f.pt = '{0, 0, 0, 1, 1, 1, 2, 2, 2};
         send_face(f);
         f.pt = '{0, 0, 0, 1, 0, 0, 0, 1, 1};
         send_face(f);
      end

      // random phases across several code tables
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: tbl = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
            1: tbl = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
            2: tbl = '{8'd1, 8'd0, 8'd128, 8'd0, 8'd254, 8'd3};
            default: foreach (tbl[i]) tbl[i] = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom);
         endcase
         write_codes(tbl);
         for (int k = 0; k < 150; k++) begin
            quiet = (ph == 2 && k < 100);
            send_face(random_face());
         end
      end
      quiet = 0;

      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (fnbc_pkg::Latency + 4) @(posedge clock);
      if (sb.mismatches == 0)
         $display("[face_normal_bc_classifier_top] OK");
      else
         $display("[face_normal_bc_classifier_top] ERROR");
      $finish;
   end

endmodule
